// ===== sv/signed_int_to_decimal_ascii_core_macros.svh =====
// Assertion macros shared by the decimal text converter.
// Depends on nothing; included by files that check their own logic.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SITD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SITD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sitd_pkg.sv =====
// Types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package sitd_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = 5;
  localparam int DIG_CNT_W  = 4;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT    = 5'd31;
  localparam logic [DIG_CNT_W-1:0] DIGITS_INIT = 4'd10;
  localparam logic [CHAR_W-1:0]    ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]    ASCII_MINUS = 7'h2D;

  typedef logic [3:0] digit_t;

  // Operation broadcast to every digit cell.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_BIT,
    CELL_DIGIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     msb_in;
  } cell_ctl_t;

endpackage

// ===== sv/sitd_if.sv =====
// Valid/ready channel interfaces for the decimal text converter.
// Depends on sitd_pkg for field widths.
`timescale 1ns / 1ps

interface sitd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sitd_pkg::CHAR_W-1:0]  character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/sitd_cell.sv =====
// One BCD digit cell of the double-dabble chain.
// Depends on sitd_pkg for the cell operation type.
`timescale 1ns / 1ps

module sitd_cell (
  input  logic                clk,
  input  sitd_pkg::cell_op_t  op,
  input  logic                bit_in,
  input  sitd_pkg::digit_t    digit_in,
  output logic                carry_out,
  output sitd_pkg::digit_t    digit_out
);
  import sitd_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // Add three before the shift so the digit wraps at ten.
  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry_out = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    unique case (op)
      CELL_HOLD:  digit_nxt = digit_r;
      CELL_CLEAR: digit_nxt = '0;
      CELL_BIT:   digit_nxt = {adj[2:0], bit_in};
      CELL_DIGIT: digit_nxt = digit_in;
      default:    digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== sv/sitd_ctrl.sv =====
// Sequencer: takes the input transaction, feeds magnitude bits into the cell
// chain, skips leading zeros and emits characters. Depends on sitd_pkg, sitd_if and the macros header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sitd_in_if.sink             in_chan,
  sitd_out_if.source          out_chan,
  input  sitd_pkg::digit_t    top_digit,
  output sitd_pkg::cell_ctl_t cell_ctl
);
  import sitd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                 state_r,   state_nxt;
  logic [VALUE_W-1:0]     mag_r,     mag_nxt;
  logic                   neg_r,     neg_nxt;
  logic [BIT_CNT_W-1:0]   bitcnt_r,  bitcnt_nxt;
  logic [DIG_CNT_W-1:0]   left_r,    left_nxt;
  logic                   ovalid_r,  ovalid_nxt;
  logic [CHAR_W-1:0]      ochar_r,   ochar_nxt;
  logic                   olast_r,   olast_nxt;
  logic                   load_ok;
  logic [VALUE_W-1:0]     raw;

  assign raw     = in_chan.value;
  assign load_ok = !ovalid_r || out_chan.ready;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = ovalid_r;
  assign out_chan.character = ochar_r;
  assign out_chan.last      = olast_r;

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    bitcnt_nxt  = bitcnt_r;
    left_nxt    = left_r;
    ovalid_nxt  = ovalid_r && !out_chan.ready;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;
    cell_ctl.op     = CELL_HOLD;
    cell_ctl.msb_in = mag_r[VALUE_W-1];

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          neg_nxt     = raw[VALUE_W-1];
          mag_nxt     = raw[VALUE_W-1] ? ('0 - raw) : raw;
          bitcnt_nxt  = '0;
          cell_ctl.op = CELL_CLEAR;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctl.op = CELL_BIT;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bitcnt_nxt  = bitcnt_r + 1'b1;
        if (bitcnt_r == LAST_BIT) begin
          left_nxt  = DIGITS_INIT;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit.
        if (top_digit == '0 && left_r != 4'd1) begin
          cell_ctl.op = CELL_DIGIT;
          left_nxt    = left_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = ASCII_MINUS;
          olast_nxt  = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          ovalid_nxt  = 1'b1;
          ochar_nxt   = ASCII_ZERO + {3'b000, top_digit};
          olast_nxt   = (left_r == 4'd1);
          cell_ctl.op = CELL_DIGIT;
          left_nxt    = left_r - 1'b1;
          if (left_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    bitcnt_r <= bitcnt_nxt;
    left_r   <= left_nxt;
    ochar_r  <= ochar_nxt;
    olast_r  <= olast_nxt;
  end

  `SITD_ASSERT_NEXT(a_conv_done, clk, rst_n, (state_r == ST_CONV && bitcnt_r == LAST_BIT),
    (state_r == ST_SKIP && left_r == DIGITS_INIT), "conversion did not end after 32 bits")
  `SITD_ASSERT_NOW(a_bcd_digit, clk, rst_n, (state_r == ST_SKIP || state_r == ST_EMIT),
    (top_digit <= 4'd9 && left_r != '0), "invalid BCD digit or digit count")
  `SITD_ASSERT_NEXT(a_last_char, clk, rst_n, (state_r == ST_EMIT && left_r == 4'd1 && load_ok),
    (state_r == ST_IDLE && ovalid_r && olast_r), "final character not marked last")

endmodule

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text. Each input transaction yields
// 1 to 11 output transactions, '-' first for negative values, then the digits
// most significant first with last set on the final one. The magnitude is
// shifted bit by bit into a chain of ten BCD digit cells (double dabble). After
// all 32 bits are in, leading zero digits are shifted out of the top cell, keeping
// at least one; then '-' for a negative value and each digit are loaded into
// the output register, which holds while the output is stalled. The next item
// is taken once the last character is in the output register.
// Depends on sitd_pkg, sitd_if, sitd_cell, sitd_ctrl.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  sitd_in_if.sink     in_chan,
  sitd_out_if.source  out_chan
);
  import sitd_pkg::*;

  cell_ctl_t cell_ctl;
  digit_t    digits [NUM_DIGITS];
  logic      carries[NUM_DIGITS];

  sitd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .top_digit (digits[NUM_DIGITS-1]),
    .cell_ctl  (cell_ctl)
  );

  // Cell 0 is the least significant digit; bits and digits move upward.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      sitd_cell u_cell (
        .clk       (clk),
        .op        (cell_ctl.op),
        .bit_in    (cell_ctl.msb_in),
        .digit_in  ('0),
        .carry_out (carries[i]),
        .digit_out (digits[i])
      );
    end else begin : g_rest
      sitd_cell u_cell (
        .clk       (clk),
        .op        (cell_ctl.op),
        .bit_in    (carries[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carries[i]),
        .digit_out (digits[i])
      );
    end
  end

endmodule
